FILE: hdl/wrvs_pkg.sv
// ----------------------------------------------------------------------------
// wrvs_pkg: shared constants for the windowed regression vertical speed block
// field widths, window size and datapath widths derived from the window radius
// ----------------------------------------------------------------------------
package wrvs_pkg;

  // samples on either side of the centre that take part in the fit
  localparam int WINDOW_RADIUS = 2;
  localparam int HIST_LEN      = 2 * WINDOW_RADIUS;
  localparam int WIN_LEN       = HIST_LEN + 1;

  // transaction field widths
  localparam int TIME_W  = 24;
  localparam int DEPTH_W = 16;
  localparam int SPEED_W = 24;

  // window index and fill count widths
  localparam int IDX_W  = $clog2(WIN_LEN);
  localparam int CNT_W  = $clog2(WIN_LEN + 1);
  localparam int GROW_W = $clog2(WIN_LEN);

  // accumulator widths
  localparam int X_W    = TIME_W + 1;
  localparam int SX_W   = X_W + GROW_W;
  localparam int SD_W   = DEPTH_W + GROW_W;
  localparam int SXX_W  = 2 * X_W - 1 + GROW_W;
  localparam int SXD_W  = X_W + DEPTH_W + 1 + GROW_W;
  localparam int MUL_W  = SX_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = SXD_W + CNT_W + 1;
  localparam int DEN_W  = SXX_W + CNT_W + 1;

  // 960 = 2^10 - 2^6, converts (1/256 m)/(1/16 s) into 1/256 m per minute
  localparam int SCALE_HI_SH = 10;
  localparam int SCALE_LO_SH = 6;
  localparam int MAG_W       = NUM_W + SCALE_HI_SH;

  // divider: quotient magnitude one bit wider than the speed field
  localparam int Q_W   = SPEED_W + 1;
  localparam int K_W   = $clog2(Q_W);
  localparam int REM_W = DEN_W - 1 + Q_W;

  localparam logic [Q_W-1:0] SPEED_POS_LIM = Q_W'((1 << (SPEED_W - 1)) - 1);
  localparam logic [Q_W-1:0] SPEED_NEG_LIM = Q_W'(1 << (SPEED_W - 1));
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W - 1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W - 1){1'b0}}};

endpackage

FILE: hdl/wrvs_if.sv
// ----------------------------------------------------------------------------
// wrvs_if: valid/ready channels of the vertical speed block
// sample channel in, speed channel out
// ----------------------------------------------------------------------------
interface wrvs_in_if;
  logic                             valid;
  logic                             ready;
  logic [wrvs_pkg::TIME_W-1:0]      sample_time;
  logic [wrvs_pkg::DEPTH_W-1:0]     depth;
  logic                             depth_present;
  logic                             end_of_dive;

  modport source (output valid, sample_time, depth, depth_present, end_of_dive,
                  input ready);
  modport sink (input valid, sample_time, depth, depth_present, end_of_dive,
                output ready);
endinterface

interface wrvs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wrvs_pkg::SPEED_W-1:0] speed;
  logic                               final_result;

  modport source (output valid, speed, final_result, input ready);
  modport sink (input valid, speed, final_result, output ready);
endinterface

FILE: hdl/windowed_regression_vertical_speed.sv
// ----------------------------------------------------------------------------
// windowed_regression_vertical_speed: sliding least-squares vertical speed
// one speed per dive sample, slope of depth over time across a 5-sample window
// ----------------------------------------------------------------------------
// usage
//   in_chan carries one dive sample per transaction (time, depth, depth flag,
//   end-of-dive mark). out_chan carries speed transactions in sample order.
//   a speed for a sample appears once two later samples arrived; the sample
//   marked end_of_dive flushes all pending speeds (up to three), the last one
//   with final_result set, and the next sample starts a new dive.
// timing
//   in_chan.ready is high only while the block is idle. a computed speed passes
//   through a setup state (S_START), then S_XX, S_XD and S_ACC per valid window
//   sample on the shared multiplier (only S_XX per missing one), S_NUM1,
//   S_NUM2, S_DEN and S_CHK for the numerator and denominator, S_DIV for
//   restoring division and S_FIN for saturation. a sample that yields no
//   speed leaves the block idle.
// reset and stall
//   synchronous active-low reset empties the history and returns to idle.
//   a held-off speed transaction waits in the output register; no new sample
//   is taken until every speed of the current sample has been delivered.
// ----------------------------------------------------------------------------
module windowed_regression_vertical_speed (
  input  logic        clk,
  input  logic        rst_n,
  wrvs_in_if.sink     in_chan,
  wrvs_out_if.source  out_chan
);

  // sequencer codes
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_START = 4'd1;
  localparam logic [ST_W-1:0] S_XX    = 4'd2;
  localparam logic [ST_W-1:0] S_XD    = 4'd3;
  localparam logic [ST_W-1:0] S_ACC   = 4'd4;
  localparam logic [ST_W-1:0] S_NUM1  = 4'd5;
  localparam logic [ST_W-1:0] S_NUM2  = 4'd6;
  localparam logic [ST_W-1:0] S_DEN   = 4'd7;
  localparam logic [ST_W-1:0] S_CHK   = 4'd8;
  localparam logic [ST_W-1:0] S_DIV   = 4'd9;
  localparam logic [ST_W-1:0] S_FIN   = 4'd10;
  localparam logic [ST_W-1:0] S_OUT   = 4'd11;

  localparam int PW = wrvs_pkg::CNT_W + 1;
  localparam logic [wrvs_pkg::CNT_W-1:0] RAD = wrvs_pkg::CNT_W'(wrvs_pkg::WINDOW_RADIUS);
  localparam logic [PW-1:0] RAD_P = PW'(wrvs_pkg::WINDOW_RADIUS);

  // multiply a wide value by the small sample count with shifted adds
  function automatic logic signed [wrvs_pkg::DEN_W-1:0] nmul(
    input logic [wrvs_pkg::CNT_W-1:0]        n,
    input logic signed [wrvs_pkg::DEN_W-1:0] v
  );
    logic signed [wrvs_pkg::DEN_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < wrvs_pkg::CNT_W; b++) begin
      if (n[b]) begin
        acc = acc + (v <<< b);
      end
    end
    return acc;
  endfunction

  // control state
  logic [ST_W-1:0]             state_r, state_nxt;
  logic [wrvs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  // sample history, oldest first
  logic [wrvs_pkg::TIME_W-1:0]  hist_tm_r [wrvs_pkg::HIST_LEN];
  logic [wrvs_pkg::TIME_W-1:0]  hist_tm_nxt [wrvs_pkg::HIST_LEN];
  logic [wrvs_pkg::DEPTH_W-1:0] hist_dp_r [wrvs_pkg::HIST_LEN];
  logic [wrvs_pkg::DEPTH_W-1:0] hist_dp_nxt [wrvs_pkg::HIST_LEN];
  logic                         hist_pr_r [wrvs_pkg::HIST_LEN];
  logic                         hist_pr_nxt [wrvs_pkg::HIST_LEN];

  // working window: history plus the new sample
  logic [wrvs_pkg::TIME_W-1:0]  win_tm_r [wrvs_pkg::WIN_LEN];
  logic [wrvs_pkg::TIME_W-1:0]  win_tm_nxt [wrvs_pkg::WIN_LEN];
  logic [wrvs_pkg::DEPTH_W-1:0] win_dp_r [wrvs_pkg::WIN_LEN];
  logic [wrvs_pkg::DEPTH_W-1:0] win_dp_nxt [wrvs_pkg::WIN_LEN];
  logic                         win_pr_r [wrvs_pkg::WIN_LEN];
  logic                         win_pr_nxt [wrvs_pkg::WIN_LEN];
  logic [wrvs_pkg::CNT_W-1:0]   len_r, len_nxt;

  // centre bookkeeping
  logic [wrvs_pkg::IDX_W-1:0]   c_r, c_nxt;
  logic [wrvs_pkg::IDX_W-1:0]   c_last_r, c_last_nxt;
  logic                         last_r, last_nxt;
  logic [wrvs_pkg::IDX_W-1:0]   j_r, j_nxt;
  logic [wrvs_pkg::IDX_W-1:0]   hi_r, hi_nxt;
  logic [wrvs_pkg::TIME_W-1:0]  ct_r, ct_nxt;

  // regression sums
  logic signed [wrvs_pkg::X_W-1:0]   x_r, x_nxt;
  logic [wrvs_pkg::DEPTH_W-1:0]      d_r, d_nxt;
  logic [wrvs_pkg::CNT_W-1:0]        n_r, n_nxt;
  logic signed [wrvs_pkg::SX_W-1:0]  sx_r, sx_nxt;
  logic [wrvs_pkg::SD_W-1:0]         sd_r, sd_nxt;
  logic signed [wrvs_pkg::SXX_W-1:0] sxx_r, sxx_nxt;
  logic signed [wrvs_pkg::SXD_W-1:0] sxd_r, sxd_nxt;

  // shared multiplier
  logic signed [wrvs_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [wrvs_pkg::PROD_W-1:0] prod_r, prod_nxt;

  // numerator, denominator and divider
  logic signed [wrvs_pkg::DEN_W-1:0] t_r, t_nxt;
  logic signed [wrvs_pkg::NUM_W-1:0] num_r, num_nxt;
  logic signed [wrvs_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [wrvs_pkg::MAG_W-1:0]        mag_r, mag_nxt;
  logic                              neg_r, neg_nxt;
  logic [wrvs_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic [wrvs_pkg::REM_W-1:0]        dv_r, dv_nxt;
  logic [wrvs_pkg::Q_W-1:0]          q_r, q_nxt;
  logic [wrvs_pkg::K_W-1:0]          k_r, k_nxt;
  logic signed [wrvs_pkg::SPEED_W-1:0] spd_r, spd_nxt;

  // combinational helpers
  logic                         in_acc;
  logic [wrvs_pkg::IDX_W-1:0]   rd_idx;
  logic [wrvs_pkg::TIME_W-1:0]  rd_tm;
  logic [wrvs_pkg::DEPTH_W-1:0] rd_dp;
  logic                         rd_pr;
  logic signed [wrvs_pkg::X_W-1:0] x_cur;
  logic [PW-1:0]                c_p, hi_p, len_m1, win_lo, win_hi;
  logic [wrvs_pkg::NUM_W-1:0]   abs_num;
  logic [wrvs_pkg::Q_W-1:0]     q_neg;
  logic                         div_ge;

  assign in_acc = in_chan.valid && in_chan.ready;

  // single read port on the window: centre at setup, then the walking index
  assign rd_idx = (state_r == S_START) ? c_r : j_r;
  assign rd_tm  = win_tm_r[rd_idx];
  assign rd_dp  = win_dp_r[rd_idx];
  assign rd_pr  = win_pr_r[rd_idx];

  // time offset from the centre sample
  assign x_cur = $signed({1'b0, rd_tm}) - $signed({1'b0, ct_r});

  // window bounds around the centre, clipped at the dive ends
  assign c_p    = PW'(c_r);
  assign hi_p   = c_p + RAD_P;
  assign len_m1 = PW'(len_r) - PW'(1);
  assign win_hi = (hi_p > len_m1) ? len_m1 : hi_p;
  assign win_lo = (c_p >= RAD_P) ? (c_p - RAD_P) : '0;

  assign prod_nxt = mul_a * mul_b;

  assign abs_num = num_r[wrvs_pkg::NUM_W-1] ? wrvs_pkg::NUM_W'(-num_r)
                                           : wrvs_pkg::NUM_W'(num_r);
  assign q_neg   = '0 - q_r;
  assign div_ge  = (rem_r >= dv_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    hist_tm_nxt = hist_tm_r;
    hist_dp_nxt = hist_dp_r;
    hist_pr_nxt = hist_pr_r;
    win_tm_nxt  = win_tm_r;
    win_dp_nxt  = win_dp_r;
    win_pr_nxt  = win_pr_r;
    len_nxt     = len_r;
    c_nxt       = c_r;
    c_last_nxt  = c_last_r;
    last_nxt    = last_r;
    j_nxt       = j_r;
    hi_nxt      = hi_r;
    ct_nxt      = ct_r;
    x_nxt       = x_r;
    d_nxt       = d_r;
    n_nxt       = n_r;
    sx_nxt      = sx_r;
    sd_nxt      = sd_r;
    sxx_nxt     = sxx_r;
    sxd_nxt     = sxd_r;
    t_nxt       = t_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    rem_nxt     = rem_r;
    dv_nxt      = dv_r;
    q_nxt       = q_r;
    k_nxt       = k_r;
    spd_nxt     = spd_r;
    mul_a       = '0;
    mul_b       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // build the window: stored samples, then the new one at the fill count
          for (int i = 0; i < wrvs_pkg::HIST_LEN; i++) begin
            win_tm_nxt[i] = hist_tm_r[i];
            win_dp_nxt[i] = hist_dp_r[i];
            win_pr_nxt[i] = hist_pr_r[i];
          end
          for (int i = 0; i < wrvs_pkg::WIN_LEN; i++) begin
            if (cnt_r == wrvs_pkg::CNT_W'(i)) begin
              win_tm_nxt[i] = in_chan.sample_time;
              win_dp_nxt[i] = in_chan.depth;
              win_pr_nxt[i] = in_chan.depth_present;
            end
          end
          len_nxt  = cnt_r + 1'b1;
          last_nxt = in_chan.end_of_dive;
          if (!in_chan.end_of_dive) begin
            if (cnt_r == wrvs_pkg::CNT_W'(wrvs_pkg::HIST_LEN)) begin
              // full history: slide by one
              for (int i = 0; i < wrvs_pkg::HIST_LEN - 1; i++) begin
                hist_tm_nxt[i] = hist_tm_r[i+1];
                hist_dp_nxt[i] = hist_dp_r[i+1];
                hist_pr_nxt[i] = hist_pr_r[i+1];
              end
              hist_tm_nxt[wrvs_pkg::HIST_LEN-1] = in_chan.sample_time;
              hist_dp_nxt[wrvs_pkg::HIST_LEN-1] = in_chan.depth;
              hist_pr_nxt[wrvs_pkg::HIST_LEN-1] = in_chan.depth_present;
            end else begin
              for (int i = 0; i < wrvs_pkg::HIST_LEN; i++) begin
                if (cnt_r == wrvs_pkg::CNT_W'(i)) begin
                  hist_tm_nxt[i] = in_chan.sample_time;
                  hist_dp_nxt[i] = in_chan.depth;
                  hist_pr_nxt[i] = in_chan.depth_present;
                end
              end
              cnt_nxt = cnt_r + 1'b1;
            end
            // one speed once the centre has enough later samples
            if (cnt_r >= RAD) begin
              c_nxt      = wrvs_pkg::IDX_W'(cnt_r - RAD);
              c_last_nxt = wrvs_pkg::IDX_W'(cnt_r - RAD);
              state_nxt  = S_START;
            end
          end else begin
            // end of dive: flush every pending centre, then start over
            cnt_nxt    = '0;
            c_nxt      = (cnt_r >= RAD) ? wrvs_pkg::IDX_W'(cnt_r - RAD) : '0;
            c_last_nxt = wrvs_pkg::IDX_W'(cnt_r);
            state_nxt  = S_START;
          end
        end
      end

      S_START: begin
        ct_nxt  = rd_tm;
        n_nxt   = '0;
        sx_nxt  = '0;
        sd_nxt  = '0;
        sxx_nxt = '0;
        sxd_nxt = '0;
        if (!rd_pr) begin
          // centre depth missing
          spd_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          j_nxt     = wrvs_pkg::IDX_W'(win_lo);
          hi_nxt    = wrvs_pkg::IDX_W'(win_hi);
          state_nxt = S_XX;
        end
      end

      S_XX: begin
        if (rd_pr) begin
          mul_a     = wrvs_pkg::MUL_W'(x_cur);
          mul_b     = wrvs_pkg::MUL_W'(x_cur);
          n_nxt     = n_r + 1'b1;
          sx_nxt    = sx_r + wrvs_pkg::SX_W'(x_cur);
          sd_nxt    = sd_r + wrvs_pkg::SD_W'(rd_dp);
          x_nxt     = x_cur;
          d_nxt     = rd_dp;
          state_nxt = S_XD;
        end else if (j_r == hi_r) begin
          state_nxt = S_NUM1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      S_XD: begin
        sxx_nxt   = sxx_r + wrvs_pkg::SXX_W'(prod_r);
        mul_a     = wrvs_pkg::MUL_W'(x_r);
        mul_b     = wrvs_pkg::MUL_W'($signed({1'b0, d_r}));
        state_nxt = S_ACC;
      end

      S_ACC: begin
        sxd_nxt = sxd_r + wrvs_pkg::SXD_W'(prod_r);
        if (j_r == hi_r) begin
          state_nxt = S_NUM1;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_XX;
        end
      end

      S_NUM1: begin
        if (n_r < wrvs_pkg::CNT_W'(2)) begin
          // fewer than two depths in the window
          spd_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          mul_a     = wrvs_pkg::MUL_W'(sx_r);
          mul_b     = wrvs_pkg::MUL_W'($signed({1'b0, sd_r}));
          t_nxt     = nmul(n_r, wrvs_pkg::DEN_W'(sxd_r));
          state_nxt = S_NUM2;
        end
      end

      S_NUM2: begin
        num_nxt   = wrvs_pkg::NUM_W'(t_r - wrvs_pkg::DEN_W'(prod_r));
        mul_a     = wrvs_pkg::MUL_W'(sx_r);
        mul_b     = wrvs_pkg::MUL_W'(sx_r);
        t_nxt     = nmul(n_r, wrvs_pkg::DEN_W'(sxx_r));
        state_nxt = S_DEN;
      end

      S_DEN: begin
        den_nxt   = t_r - wrvs_pkg::DEN_W'(prod_r);
        neg_nxt   = num_r[wrvs_pkg::NUM_W-1];
        mag_nxt   = (wrvs_pkg::MAG_W'(abs_num) << wrvs_pkg::SCALE_HI_SH)
                  - (wrvs_pkg::MAG_W'(abs_num) << wrvs_pkg::SCALE_LO_SH);
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (den_r[wrvs_pkg::DEN_W-1] || (den_r == '0)) begin
          // all valid times equal
          spd_nxt   = '0;
          state_nxt = S_OUT;
        end else if (wrvs_pkg::REM_W'(mag_r) >=
                     (wrvs_pkg::REM_W'(den_r[wrvs_pkg::DEN_W-2:0]) << wrvs_pkg::Q_W)) begin
          // quotient beyond the divider range saturates anyway
          spd_nxt   = neg_r ? wrvs_pkg::SPEED_MIN : wrvs_pkg::SPEED_MAX;
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = wrvs_pkg::REM_W'(mag_r);
          dv_nxt    = wrvs_pkg::REM_W'(den_r[wrvs_pkg::DEN_W-2:0]) << (wrvs_pkg::Q_W - 1);
          q_nxt     = '0;
          k_nxt     = wrvs_pkg::K_W'(wrvs_pkg::Q_W - 1);
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (div_ge) begin
          rem_nxt = rem_r - dv_r;
        end
        q_nxt  = {q_r[wrvs_pkg::Q_W-2:0], div_ge};
        dv_nxt = dv_r >> 1;
        if (k_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end

      S_FIN: begin
        // truncated toward zero, saturate to the speed range
        if (neg_r) begin
          spd_nxt = (q_r > wrvs_pkg::SPEED_NEG_LIM) ? wrvs_pkg::SPEED_MIN
                                                   : $signed(q_neg[wrvs_pkg::SPEED_W-1:0]);
        end else begin
          spd_nxt = (q_r > wrvs_pkg::SPEED_POS_LIM) ? wrvs_pkg::SPEED_MAX
                                                   : $signed(q_r[wrvs_pkg::SPEED_W-1:0]);
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_chan.ready) begin
          if (c_r == c_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    hist_tm_r <= hist_tm_nxt;
    hist_dp_r <= hist_dp_nxt;
    hist_pr_r <= hist_pr_nxt;
    win_tm_r  <= win_tm_nxt;
    win_dp_r  <= win_dp_nxt;
    win_pr_r  <= win_pr_nxt;
    len_r     <= len_nxt;
    c_r       <= c_nxt;
    c_last_r  <= c_last_nxt;
    last_r    <= last_nxt;
    j_r       <= j_nxt;
    hi_r      <= hi_nxt;
    ct_r      <= ct_nxt;
    x_r       <= x_nxt;
    d_r       <= d_nxt;
    n_r       <= n_nxt;
    sx_r      <= sx_nxt;
    sd_r      <= sd_nxt;
    sxx_r     <= sxx_nxt;
    sxd_r     <= sxd_nxt;
    prod_r    <= prod_nxt;
    t_r       <= t_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    rem_r     <= rem_nxt;
    dv_r      <= dv_nxt;
    q_r       <= q_nxt;
    k_r       <= k_nxt;
    spd_r     <= spd_nxt;
  end

  // channel outputs
  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = (state_r == S_OUT);
  assign out_chan.speed        = spd_r;
  assign out_chan.final_result = last_r && (c_r == c_last_r);

  // checks

  // restoring division never leaves a remainder of twice the shifted divisor
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, rem_r} < {dv_r, 1'b0}))
    else $error("divider remainder out of range");

  // the end-of-dive transaction empties the history
  a_eod_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.end_of_dive) |=> (cnt_r == '0))
    else $error("history not cleared after end of dive");

  // the fill count stays within the history
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wrvs_pkg::CNT_W'(wrvs_pkg::HIST_LEN))
    else $error("fill count beyond history length");

  // a presented speed never belongs to a centre past the flush end
  a_centre_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (c_r <= c_last_r))
    else $error("centre index past last pending centre");

endmodule

FILE: sim/windowed_regression_vertical_speed_tb.sv
// ----------------------------------------------------------------------------
// windowed_regression_vertical_speed_tb: self-checking bench for the speed block
// feeds whole dives of samples through the input channel and checks every
// speed transaction against a least-squares slope computed in the bench
// ----------------------------------------------------------------------------
module windowed_regression_vertical_speed_tb;

  // run control
  localparam int  HALF_PERIOD  = 5;
  localparam int  RESET_CYCLES = 5;
  localparam int  IDLE_PCT     = 18;
  localparam int  SAMPLE_GOAL  = 460;
  localparam int  DRAIN_CYCLES = 300;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  MAX_PRINTS   = 30;
  // stretch of accepted samples during which neither side idles
  localparam int  STEADY_FROM  = 200;
  localparam int  STEADY_TO    = 300;

  // slope arithmetic
  localparam longint SPEED_SCALE  = 960;  // (1/256 m)/(1/16 s) into 1/256 m per minute
  localparam longint SPEED_TOP    = (longint'(1) << (wrvs_pkg::SPEED_W - 1)) - 1;
  localparam longint SPEED_BOTTOM = -(longint'(1) << (wrvs_pkg::SPEED_W - 1));
  localparam int     DEPTH_TOP    = (1 << wrvs_pkg::DEPTH_W) - 1;
  localparam int     TIME_TOP     = (1 << wrvs_pkg::TIME_W) - 1;

  typedef struct packed {
    logic [wrvs_pkg::TIME_W-1:0]  sample_time;
    logic [wrvs_pkg::DEPTH_W-1:0] depth;
    logic                         depth_present;
    logic                         end_of_dive;
  } dive_sample_t;

  typedef struct packed {
    logic signed [wrvs_pkg::SPEED_W-1:0] speed;
    logic                                final_result;
  } speed_rec_t;

  logic clk;
  logic rst_n;

  wrvs_in_if  in_chan ();
  wrvs_out_if out_chan ();

  windowed_regression_vertical_speed uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // samples waiting to be driven, speeds waiting to be seen
  dive_sample_t sample_q[$];
  speed_rec_t   speed_q[$];

  int  mismatches;
  int  samples_taken;
  int  cycle_count;
  bit  sample_taken_now;
  bit  steady;

  // history of the current dive, oldest first
  logic [wrvs_pkg::TIME_W-1:0]  hist_time    [wrvs_pkg::HIST_LEN];
  logic [wrvs_pkg::DEPTH_W-1:0] hist_depth   [wrvs_pkg::HIST_LEN];
  logic                         hist_present [wrvs_pkg::HIST_LEN];
  int                           hist_fill;

  // window under evaluation: history plus the new sample
  logic [wrvs_pkg::TIME_W-1:0]  win_time    [wrvs_pkg::WIN_LEN];
  logic [wrvs_pkg::DEPTH_W-1:0] win_depth   [wrvs_pkg::WIN_LEN];
  logic                         win_present [wrvs_pkg::WIN_LEN];

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // no idling on either side in the middle of the run
  assign steady = (samples_taken >= STEADY_FROM) && (samples_taken < STEADY_TO);

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // least-squares slope around window position centre, window clipped to len
  function automatic logic signed [wrvs_pkg::SPEED_W-1:0] window_slope(input int len,
                                                                       input int centre);
    int     lo;
    int     hi;
    longint n;
    longint sx;
    longint sd;
    longint sxx;
    longint sxd;
    longint x;
    longint d;
    longint num;
    longint den;
    longint q;
    if (!win_present[centre])
      return '0;
    lo = (centre - wrvs_pkg::WINDOW_RADIUS < 0) ? 0 : centre - wrvs_pkg::WINDOW_RADIUS;
    hi = (centre + wrvs_pkg::WINDOW_RADIUS > len - 1) ? len - 1
                                                      : centre + wrvs_pkg::WINDOW_RADIUS;
    n = 0; sx = 0; sd = 0; sxx = 0; sxd = 0;
    for (int j = lo; j <= hi; j++) begin
      if (win_present[j]) begin
        // time offsets are signed, so a decreasing time just goes negative
        x = longint'(win_time[j]) - longint'(win_time[centre]);
        d = longint'(win_depth[j]);
        n++;
        sx  += x;
        sd  += d;
        sxx += x * x;
        sxd += x * d;
      end
    end
    if (n < 2)
      return '0;
    num = n * sxd - sx * sd;
    den = n * sxx - sx * sx;
    if (den <= 0)
      return '0;
    q = (num * SPEED_SCALE) / den;  // truncates toward zero
    if (q > SPEED_TOP)
      q = SPEED_TOP;
    if (q < SPEED_BOTTOM)
      q = SPEED_BOTTOM;
    return q[wrvs_pkg::SPEED_W-1:0];
  endfunction

  // expected speeds caused by one accepted sample, and the history update
  task automatic predict_speeds(input dive_sample_t s);
    int         cnt;
    int         len;
    int         first;
    speed_rec_t rec;
    cnt = hist_fill;
    for (int i = 0; i < cnt; i++) begin
      win_time[i]    = hist_time[i];
      win_depth[i]   = hist_depth[i];
      win_present[i] = hist_present[i];
    end
    win_time[cnt]    = s.sample_time;
    win_depth[cnt]   = s.depth;
    win_present[cnt] = s.depth_present;
    len   = cnt + 1;
    first = len - 1 - wrvs_pkg::WINDOW_RADIUS;
    if (!s.end_of_dive) begin
      // one speed once the centre has its later neighbours
      if (first >= 0) begin
        rec.speed        = window_slope(len, first);
        rec.final_result = 1'b0;
        speed_q.push_back(rec);
      end
      if (cnt == wrvs_pkg::HIST_LEN) begin
        for (int i = 0; i < wrvs_pkg::HIST_LEN; i++) begin
          hist_time[i]    = win_time[i + 1];
          hist_depth[i]   = win_depth[i + 1];
          hist_present[i] = win_present[i + 1];
        end
      end else begin
        hist_time[cnt]    = win_time[cnt];
        hist_depth[cnt]   = win_depth[cnt];
        hist_present[cnt] = win_present[cnt];
        hist_fill         = cnt + 1;
      end
    end else begin
      // end of dive flushes every pending centre, last one marked
      if (first < 0)
        first = 0;
      for (int c = first; c < len; c++) begin
        rec.speed        = window_slope(len, c);
        rec.final_result = (c == len - 1);
        speed_q.push_back(rec);
      end
      hist_fill = 0;
      for (int i = 0; i < wrvs_pkg::HIST_LEN; i++) begin
        hist_time[i]    = '0;
        hist_depth[i]   = '0;
        hist_present[i] = 1'b0;
      end
    end
  endtask

  task automatic add_sample(input int t, input int d, input bit p, input bit e);
    dive_sample_t s;
    s.sample_time   = t[wrvs_pkg::TIME_W-1:0];
    s.depth         = d[wrvs_pkg::DEPTH_W-1:0];
    s.depth_present = p;
    s.end_of_dive   = e;
    sample_q.push_back(s);
  endtask

  // one random dive: mostly a plausible profile, sometimes pure noise
  task automatic add_random_dive();
    int len;
    int t;
    int d;
    int step;
    bit noisy;
    bit p;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
    noisy = ($urandom_range(0, 99) < 15);
    t     = $urandom_range(0, TIME_TOP);
    d     = $urandom_range(0, DEPTH_TOP);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        t = $urandom_range(0, TIME_TOP);
        d = $urandom_range(0, DEPTH_TOP);
        p = $urandom_range(0, 1);
      end else begin
        case ($urandom_range(0, 9))
          0: step = 0;                                // repeated time stamp
          1: step = $urandom_range(0, 1 << 20);       // long gap
          default: step = $urandom_range(1, 40);
        endcase
        if (i > 0)
          t = (t + step) & TIME_TOP;                  // wrap gives a rare time step back
        if ($urandom_range(0, 19) == 0)
          d = $urandom_range(0, DEPTH_TOP);
        else
          d = d + $urandom_range(0, 4000) - 2000;
        if (d < 0)
          d = 0;
        if (d > DEPTH_TOP)
          d = DEPTH_TOP;
        p = ($urandom_range(0, 99) >= 12);
      end
      add_sample(t, d, p, i == len - 1);
    end
  endtask

  // input driver: a held transaction stays until taken, new ones start at random
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_chan.valid || sample_taken_now) begin
        if (sample_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_chan.valid         <= 1'b1;
          in_chan.sample_time   <= sample_q[0].sample_time;
          in_chan.depth         <= sample_q[0].depth;
          in_chan.depth_present <= sample_q[0].depth_present;
          in_chan.end_of_dive   <= sample_q[0].end_of_dive;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
    sample_taken_now = 1'b0;
  end

  // accepted samples feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      predict_speeds(sample_q[0]);
      void'(sample_q.pop_front());
      sample_taken_now = 1'b1;
      samples_taken++;
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    out_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // speed monitor: each transaction against the oldest expectation
  always @(posedge clk) begin
    speed_rec_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (speed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected speed transaction %0d", out_chan.speed));
      end else begin
        want = speed_q.pop_front();
        if (out_chan.speed !== want.speed)
          report_mismatch($sformatf("speed %0d, expected %0d", out_chan.speed, want.speed));
        if (out_chan.final_result !== want.final_result)
          report_mismatch($sformatf("final_result %b, expected %b",
                                    out_chan.final_result, want.final_result));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.sample_time   = '0;
    in_chan.depth         = '0;
    in_chan.depth_present = 1'b0;
    in_chan.end_of_dive   = 1'b0;
    out_chan.ready        = 1'b0;
    mismatches            = 0;
    samples_taken         = 0;
    cycle_count           = 0;
    sample_taken_now      = 1'b0;
    hist_fill             = 0;
    for (int i = 0; i < wrvs_pkg::HIST_LEN; i++) begin
      hist_time[i]    = '0;
      hist_depth[i]   = '0;
      hist_present[i] = 1'b0;
    end

    // steady descent, full window in the middle, flush of three at the end
    add_sample(0,    0, 1, 0);
    add_sample(16, 256, 1, 0);
    add_sample(32, 512, 1, 0);
    add_sample(48, 768, 1, 0);
    add_sample(64, 1024, 1, 1);
    // depth swings between the extremes one tick apart: positive saturation limit
    add_sample(0, 0, 1, 0);
    add_sample(1, DEPTH_TOP, 1, 0);
    add_sample(2, 0, 1, 0);
    add_sample(3, DEPTH_TOP, 1, 1);
    // missing centre depth, and a lone valid depth in its window
    add_sample(100, 0, 0, 0);
    add_sample(110, 5000, 1, 0);
    add_sample(120, DEPTH_TOP, 0, 0);
    add_sample(130, 0, 0, 1);
    // all times equal at the top of the range: zero denominator
    add_sample(TIME_TOP, DEPTH_TOP, 1, 0);
    add_sample(TIME_TOP, 0, 1, 0);
    add_sample(TIME_TOP, DEPTH_TOP, 1, 1);
    // time running backwards
    add_sample(5000, 1000, 1, 0);
    add_sample(4000, 2000, 1, 0);
    add_sample(3000, 4000, 1, 0);
    add_sample(2000, 8000, 1, 1);
    // dive of one sample, then a dive of two
    add_sample(777, 3000, 1, 1);
    add_sample(TIME_TOP - 5, 40000, 1, 0);
    add_sample(TIME_TOP, 65000, 1, 1);

    while (sample_q.size() < SAMPLE_GOAL)
      add_random_dive();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all samples taken, all speeds seen, then let the block settle
    wait (sample_q.size() == 0);
    wait (speed_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (speed_q.size() != 0)
      report_mismatch($sformatf("%0d speed transactions never arrived", speed_q.size()));

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
